// ===== rtl/tme_pkg.sv =====
package tme_pkg;

    localparam int TAPE_AW    = 15;
    localparam int TAPE_DEPTH = 1 << TAPE_AW;
    localparam int IDX_W      = 12;
    localparam int NEXT_W     = 13;
    localparam int AMT_W      = 16;
    localparam int BYTE_W     = 8;

    typedef logic [TAPE_AW-1:0] t_addr;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [NEXT_W-1:0]  t_next;

    typedef enum logic [2:0] {
        OP_MOVE  = 3'd0,
        OP_ADD   = 3'd1,
        OP_OUT   = 3'd2,
        OP_IN    = 3'd3,
        OP_BEGIN = 3'd4,
        OP_END   = 3'd5,
        OP_ZERO  = 3'd6
    } t_op;

    typedef struct packed {
        logic  en;
        t_addr addr;
        t_byte data;
    } t_tape_wr;

endpackage

// ===== rtl/tme_tape_ram.sv =====
module tme_tape_ram (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  tme_pkg::t_addr   i_rd_addr,
    output tme_pkg::t_byte   o_rd_data,
    input  tme_pkg::t_tape_wr i_wr,
    output logic             o_busy
);
    import tme_pkg::*;

    t_byte mem [TAPE_DEPTH];
    t_byte r_rd_data;
    t_addr r_clr_addr;
    logic  r_clearing;
    t_addr wr_addr;
    t_byte wr_data;
    logic  wr_en;

    // The clearing sweep owns the write port until every cell holds zero.
    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr.en;
            wr_addr = i_wr.addr;
            wr_data = i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + t_addr'(1);
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

    a_no_wr_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_wr.en && !i_rd_en)
        else $error("tape access during clearing sweep");

    a_sweep_addr_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clearing |-> r_clr_addr == '0)
        else $error("sweep address moved after the sweep ended");

    a_sweep_ends_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> $past(r_clr_addr) == '1)
        else $error("sweep ended before the last cell");

endmodule

// ===== rtl/tape_machine_instruction_executor_core.sv =====
// Flow: an instruction enters the stage-one registers on transfer, and its result
// enters the output registers when stage one advances. Throughput: one instruction
// per cycle while o_stall is low; the tape cell is read on transfer and written back
// as stage one advances, with the last write forwarded to the next read.
// Reset: synchronous, active low. After reset the tape is swept to zero, one cell
// per cycle, through all 32768 cells; no instruction is taken during the sweep.
module tape_machine_instruction_executor_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [2:0]                     i_req_type,
    input  logic [tme_pkg::IDX_W-1:0]      i_inst_index,
    input  logic signed [tme_pkg::AMT_W-1:0] i_amount,
    input  logic [tme_pkg::IDX_W-1:0]      i_branch_target,
    input  logic [tme_pkg::BYTE_W-1:0]     i_in_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tme_pkg::NEXT_W-1:0]     o_next_index,
    output logic                           o_branch_taken,
    output logic                           o_out_valid,
    output logic [tme_pkg::BYTE_W-1:0]     o_out_byte
);
    import tme_pkg::*;

    // Pointer and stage controls.
    t_addr    r_ptr;
    logic     r_s1_v;
    t_op      r_s1_op;
    t_idx     r_s1_idx;
    t_idx     r_s1_tgt;
    t_byte    r_s1_amt;
    t_byte    r_s1_inb;
    t_addr    r_s1_addr;
    t_tape_wr r_wr;
    t_tape_wr n_wr;

    logic     r_o_v;
    t_next    r_o_next;
    logic     r_o_taken;
    logic     r_o_outv;
    t_byte    r_o_byte;

    logic     accept;
    logic     s1_adv;
    logic     busy;
    t_byte    rd_data;
    t_byte    cur_byte;
    t_next    n_next;
    logic     n_taken;
    logic     n_outv;
    t_byte    n_byte;

    tme_tape_ram u_tape (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_data),
        .i_wr      (n_wr),
        .o_busy    (busy)
    );

    assign s1_adv  = r_s1_v && (!r_o_v || !i_stall);
    assign o_stall = busy || (r_s1_v && !s1_adv);
    assign accept  = i_valid && !o_stall;

    // The previous write may land on the same edge as this read was issued.
    assign cur_byte = (r_wr.en && (r_wr.addr == r_s1_addr)) ? r_wr.data : rd_data;

    always_comb begin
        n_next       = {1'b0, r_s1_idx} + t_next'(1);
        n_taken      = 1'b0;
        n_outv       = 1'b0;
        n_byte       = '0;
        n_wr.en      = 1'b0;
        n_wr.addr    = r_s1_addr;
        n_wr.data    = '0;
        case (r_s1_op)
            OP_ADD: begin
                n_wr.en   = 1'b1;
                n_wr.data = cur_byte + r_s1_amt;
            end
            OP_OUT: begin
                n_outv = 1'b1;
                n_byte = cur_byte;
            end
            OP_IN: begin
                n_wr.en   = 1'b1;
                n_wr.data = r_s1_inb;
            end
            OP_BEGIN: begin
                if (cur_byte == '0) begin
                    n_taken = 1'b1;
                    n_next  = {1'b0, r_s1_tgt} + t_next'(1);
                end
            end
            OP_END: begin
                if (cur_byte != '0) begin
                    n_taken = 1'b1;
                    n_next  = {1'b0, r_s1_tgt} + t_next'(1);
                end
            end
            OP_ZERO: begin
                n_wr.en = 1'b1;
            end
            default: begin
            end
        endcase
        n_wr.en = n_wr.en && s1_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
            r_wr   <= '0;
        end else begin
            if (accept && (t_op'(i_req_type) == OP_MOVE)) begin
                r_ptr <= r_ptr + t_addr'(i_amount);
            end
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_o_v <= 1'b1;
            end else if (!i_stall) begin
                r_o_v <= 1'b0;
            end
            if (s1_adv) begin
                r_wr <= n_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= t_op'(i_req_type);
            r_s1_idx  <= i_inst_index;
            r_s1_tgt  <= i_branch_target;
            r_s1_amt  <= i_amount[BYTE_W-1:0];
            r_s1_inb  <= i_in_byte;
            r_s1_addr <= r_ptr;
        end
        if (s1_adv) begin
            r_o_next  <= n_next;
            r_o_taken <= n_taken;
            r_o_outv  <= n_outv;
            r_o_byte  <= n_byte;
        end
    end

    assign o_valid        = r_o_v;
    assign o_next_index   = r_o_next;
    assign o_branch_taken = r_o_taken;
    assign o_out_valid    = r_o_outv;
    assign o_out_byte     = r_o_byte;

    a_no_transfer_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !accept && !r_s1_v)
        else $error("instruction taken while the tape is being cleared");

    a_byte_only_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && !r_o_outv |-> r_o_byte == '0)
        else $error("output byte set on a non-output result");

    a_branch_not_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && r_o_taken |-> !r_o_outv)
        else $error("branch and output flagged together");

    a_write_follows_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_wr.en |-> r_s1_v && (r_s1_op == OP_ADD || r_s1_op == OP_IN || r_s1_op == OP_ZERO))
        else $error("tape write without a writing instruction in stage one");

endmodule

// ===== verif/tape_machine_instruction_executor_checker.sv =====
module tape_machine_instruction_executor_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_stall,
    input  logic [2:0]                  i_req_type,
    input  tme_pkg::t_idx               i_inst_index,
    input  logic signed [tme_pkg::AMT_W-1:0] i_amount,
    input  tme_pkg::t_idx               i_branch_target,
    input  tme_pkg::t_byte              i_in_byte,
    input  logic                        i_res_valid,
    input  logic                        i_res_stall,
    input  tme_pkg::t_next              i_next_index,
    input  logic                        i_branch_taken,
    input  logic                        i_out_valid,
    input  tme_pkg::t_byte              i_out_byte,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        tme_pkg::t_next next_index;
        logic           branch_taken;
        logic           out_valid;
        tme_pkg::t_byte out_byte;
    } t_retire;

    tme_pkg::t_byte tape [tme_pkg::TAPE_DEPTH];
    tme_pkg::t_addr cell_ptr;
    t_retire        retire_q [$];
    int             mismatches = 0;

    assign o_fail_count = mismatches;

    // Executes one instruction on the local tape copy and returns what the
    // block should retire for it.
    function automatic t_retire exec_instr(input logic [2:0] op, input tme_pkg::t_idx idx,
                                           input logic signed [tme_pkg::AMT_W-1:0] amt,
                                           input tme_pkg::t_idx tgt, input tme_pkg::t_byte inb);
        t_retire        r;
        tme_pkg::t_byte cur;
        logic           taken;
        r     = '0;
        cur   = tape[cell_ptr];
        taken = 1'b0;
        case (op)
            tme_pkg::OP_MOVE: begin
                // The tape depth divides 2^16, so the low pointer bits of the
                // amount give the wrapped move in both directions.
                cell_ptr = cell_ptr + amt[tme_pkg::TAPE_AW-1:0];
            end
            tme_pkg::OP_ADD: begin
                tape[cell_ptr] = cur + amt[7:0];
            end
            tme_pkg::OP_OUT: begin
                r.out_valid = 1'b1;
                r.out_byte  = cur;
            end
            tme_pkg::OP_IN: begin
                tape[cell_ptr] = inb;
            end
            tme_pkg::OP_BEGIN: begin
                taken = (cur == '0);
            end
            tme_pkg::OP_END: begin
                taken = (cur != '0);
            end
            tme_pkg::OP_ZERO: begin
                tape[cell_ptr] = '0;
            end
            default: begin
            end
        endcase
        r.branch_taken = taken;
        r.next_index   = taken ? {1'b0, tgt} + tme_pkg::t_next'(1)
                               : {1'b0, idx} + tme_pkg::t_next'(1);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : retire_check
        t_retire got;
        t_retire want;
        int      k;
        if (!i_rst_n) begin
            for (k = 0; k < tme_pkg::TAPE_DEPTH; k++) begin
                tape[k] = '0;
            end
            cell_ptr = '0;
            retire_q.delete();
        end else begin
            // A result never leaves in the cycle of its own instruction
            // transfer, so the result side is handled first.
            if (i_res_valid && !i_res_stall) begin
                got.next_index   = i_next_index;
                got.branch_taken = i_branch_taken;
                got.out_valid    = i_out_valid;
                got.out_byte     = i_out_byte;
                if (retire_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = retire_q.pop_front();
                    check_field("next_index", want.next_index, got.next_index);
                    check_field("branch_taken", want.branch_taken, got.branch_taken);
                    check_field("out_valid", want.out_valid, got.out_valid);
                    check_field("out_byte", want.out_byte, got.out_byte);
                end
            end
            if (i_req_valid && !i_req_stall) begin
                retire_q.push_back(exec_instr(i_req_type, i_inst_index, i_amount,
                                              i_branch_target, i_in_byte));
            end
        end
        o_pending <= retire_q.size();
    end

endmodule

// ===== verif/tape_machine_instruction_executor_core_tb.sv =====
module tape_machine_instruction_executor_core_tb;

    localparam int TOTAL_ITEMS    = 1450;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int SETTLE_CYCLES  = 8;
    // Code 7 is unused and executes as a no-op.
    localparam logic [2:0] OP_NOP = 3'd7;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             req_valid = 1'b0;
    logic                             req_stall;
    logic [2:0]                       req_type = '0;
    tme_pkg::t_idx                    inst_index = '0;
    logic signed [tme_pkg::AMT_W-1:0] amount = '0;
    tme_pkg::t_idx                    branch_target = '0;
    tme_pkg::t_byte                   in_byte = '0;
    logic                             res_valid;
    logic                             res_stall = 1'b0;
    tme_pkg::t_next                   next_index;
    logic                             branch_taken;
    logic                             out_valid;
    tme_pkg::t_byte                   out_byte;

    logic req_xfer_q = 1'b0;
    logic res_xfer_q = 1'b0;
    logic idle_en = 1'b1;
    int   quiet_cycles = 0;
    int   sent = 0;
    int   fail_count;
    int   pending;

    tape_machine_instruction_executor_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_stall         (req_stall),
        .i_req_type      (req_type),
        .i_inst_index    (inst_index),
        .i_amount        (amount),
        .i_branch_target (branch_target),
        .i_in_byte       (in_byte),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_next_index    (next_index),
        .o_branch_taken  (branch_taken),
        .o_out_valid     (out_valid),
        .o_out_byte      (out_byte)
    );

    tape_machine_instruction_executor_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_req_type      (req_type),
        .i_inst_index    (inst_index),
        .i_amount        (amount),
        .i_branch_target (branch_target),
        .i_in_byte       (in_byte),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_next_index    (next_index),
        .i_branch_taken  (branch_taken),
        .i_out_valid     (out_valid),
        .i_out_byte      (out_byte),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transfers are registered at the rising edge so that the drivers, which
    // work on the falling edge, see settled flags.
    always @(posedge clk) begin
        req_xfer_q <= req_valid && !req_stall;
        res_xfer_q <= res_valid && !res_stall;
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Result side: while idle_en is set, raises the stall for a random hold before
    // each transfer; otherwise it does not stall.
    initial begin : result_sink
        int unsigned hold;
        wait (rst_n);
        forever begin
            hold = idle_en ? $urandom_range(0, 5) : 0;
            if (hold != 0) begin
                res_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            res_stall = 1'b0;
            do @(negedge clk); while (!res_xfer_q);
        end
    end

    task automatic send_instr(input logic [2:0] op, input tme_pkg::t_idx idx,
                              input logic signed [tme_pkg::AMT_W-1:0] amt,
                              input tme_pkg::t_idx tgt, input tme_pkg::t_byte inb);
        int unsigned gap;
        gap = idle_en ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid     = 1'b1;
        req_type      = op;
        inst_index    = idx;
        amount        = amt;
        branch_target = tgt;
        in_byte       = inb;
        do @(negedge clk); while (!req_xfer_q);
        sent++;
    endtask

    initial begin : stimulus
        tme_pkg::t_idx                    pc;
        tme_pkg::t_idx                    idx;
        tme_pkg::t_idx                    loop_head;
        logic [2:0]                       op;
        logic signed [tme_pkg::AMT_W-1:0] amt;
        int unsigned                      draw;
        int unsigned                      count;
        int                               blocks;
        int                               j;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: cleared tape, branches in both directions with the
        // next index past the program end, cell and pointer wrap, extremes.
        send_instr(tme_pkg::OP_OUT,   12'd0,   16'sd0,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_BEGIN, 12'd1,   16'sd0,     12'hFFF, 8'h00);
        send_instr(tme_pkg::OP_END,   12'hFFF, 16'sd0,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_IN,    12'd2,   16'sd0,     12'd0,   8'hFF);
        send_instr(tme_pkg::OP_OUT,   12'd3,   16'sd0,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_END,   12'd4,   16'sd0,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_BEGIN, 12'd5,   16'sd0,     12'hFFF, 8'h00);
        send_instr(tme_pkg::OP_ADD,   12'd6,   16'sd1,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_OUT,   12'd7,   16'sd0,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_ADD,   12'd8,   16'sh8000,  12'd0,   8'h00);
        send_instr(tme_pkg::OP_ADD,   12'd9,   16'sh7FFF,  12'd0,   8'h00);
        send_instr(tme_pkg::OP_OUT,   12'd10,  16'sd0,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_MOVE,  12'd11,  -16'sd1,    12'd0,   8'h00);
        send_instr(tme_pkg::OP_OUT,   12'd12,  16'sd0,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_IN,    12'd13,  16'sd0,     12'd0,   8'hA5);
        send_instr(tme_pkg::OP_MOVE,  12'd14,  16'sd1,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_OUT,   12'd15,  16'sd0,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_MOVE,  12'd16,  16'sh8000,  12'd0,   8'h00);
        send_instr(tme_pkg::OP_MOVE,  12'd17,  16'sh7FFF,  12'd0,   8'h00);
        send_instr(tme_pkg::OP_OUT,   12'd18,  16'sd0,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_ZERO,  12'd19,  16'sd0,     12'd0,   8'h00);
        send_instr(tme_pkg::OP_OUT,   12'd20,  16'sd0,     12'd0,   8'h00);
        send_instr(OP_NOP,            12'hFFF, -16'sd1,    12'hFFF, 8'hFF);
        send_instr(tme_pkg::OP_MOVE,  12'd21,  16'sd1,     12'd0,   8'h00);

        pc     = 12'd22;
        blocks = 0;
        while (sent < TOTAL_ITEMS) begin
            blocks++;
            if (blocks % 40 == 0) begin
                idle_en = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) < 2) begin
                // A counted loop: load a count, then decrement and print until the
                // cell reaches zero; a zero count still sends the loop body once.
                count = $urandom_range(0, 5);
                send_instr(tme_pkg::OP_IN, pc, 16'($urandom), 12'($urandom), 8'(count));
                loop_head = pc + 12'd1;
                send_instr(tme_pkg::OP_BEGIN, loop_head, 16'($urandom), loop_head + 12'd3,
                           8'($urandom));
                for (j = 0; j < ((count == 0) ? 1 : count); j++) begin
                    send_instr(tme_pkg::OP_ADD, loop_head + 12'd1, -16'sd1, 12'($urandom),
                               8'($urandom));
                    send_instr(tme_pkg::OP_OUT, loop_head + 12'd2, 16'($urandom),
                               12'($urandom), 8'($urandom));
                    send_instr(tme_pkg::OP_END, loop_head + 12'd3, 16'($urandom), loop_head,
                               8'($urandom));
                end
                pc = loop_head + 12'd4;
            end else begin
                draw = $urandom_range(0, 99);
                if (draw < 15) begin
                    op = tme_pkg::OP_MOVE;
                end else if (draw < 40) begin
                    op = tme_pkg::OP_ADD;
                end else if (draw < 55) begin
                    op = tme_pkg::OP_OUT;
                end else if (draw < 65) begin
                    op = tme_pkg::OP_IN;
                end else if (draw < 77) begin
                    op = tme_pkg::OP_BEGIN;
                end else if (draw < 89) begin
                    op = tme_pkg::OP_END;
                end else if (draw < 97) begin
                    op = tme_pkg::OP_ZERO;
                end else begin
                    op = OP_NOP;
                end
                amt = 16'($urandom);
                // Small moves keep the pointer in a busy region around the
                // wrap point so that cells are revisited.
                if (op == tme_pkg::OP_MOVE && $urandom_range(0, 9) != 0) begin
                    amt = 16'(int'($urandom_range(0, 8)) - 4);
                end
                if (op == tme_pkg::OP_ADD && $urandom_range(0, 9) < 7) begin
                    amt = 16'(int'($urandom_range(0, 6)) - 3);
                end
                idx = ($urandom_range(0, 9) == 0) ? 12'($urandom) : pc;
                send_instr(op, idx, amt, 12'($urandom), 8'($urandom));
                pc = idx + 12'd1;
            end
        end
        req_valid = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tme_pkg.sv
rtl/tme_tape_ram.sv
rtl/tape_machine_instruction_executor_core.sv
verif/tape_machine_instruction_executor_checker.sv
verif/tape_machine_instruction_executor_core_tb.sv
